[design/seu_pkg.sv]
// Shared command and status types for the escape decoder controller and datapath.
package seu_pkg;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take the input transfer: update the decode state and plan the results
    logic step;   // write the next planned result into the output register
  } seu_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic has_more;  // planned results remain
    logic is_final;  // the next result is the last one of the plan
    logic out_free;  // the output register can take a result this cycle
  } seu_sts_t;

endpackage

[design/seu_if.sv]
// Valid/ready channel interfaces for the escape decoder input and output.
interface seu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface seu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       bad_escape;
  logic       run_last;
  logic       string_end;

  modport source (output valid, output out_byte, output byte_valid, output bad_escape,
                  output run_last, output string_end, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input bad_escape,
                  input run_last, input string_end, output ready);
endinterface

[design/seu_datapath.sv]
// Escape decoder datapath: decode state, hex digit store, result sequencer, output register.
module seu_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        in_byte_i,
  input  logic              is_last_i,
  input  seu_pkg::seu_cmd_t cmd_i,
  output seu_pkg::seu_sts_t sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [7:0]        out_byte_o,
  output logic              byte_valid_o,
  output logic              bad_escape_o,
  output logic              run_last_o,
  output logic              string_end_o
);
  import seu_pkg::*;

  typedef enum logic [1:0] {
    PH_TEXT = 2'd0,
    PH_ESC  = 2'd1,
    PH_HEX  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_BYTE,
    TAIL_UTF8,
    TAIL_MARK
  } tail_e;

  localparam logic [7:0]  BACKSLASH    = 8'h5C;
  localparam logic [7:0]  ESC_CODE     = 8'h1B;
  localparam logic [7:0]  CONT_TAG     = 8'h80;
  localparam logic [7:0]  CONT_MASK    = 8'h3F;
  localparam logic [31:0] ONE_BYTE_MAX = 32'h0000_007F;

  // {ok, value} of an ASCII hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    case (b) inside
      [8'h30:8'h39]: return {1'b1, 4'(b - 8'h30)};
      [8'h61:8'h66]: return {1'b1, 4'(b - 8'h57)};
      [8'h41:8'h46]: return {1'b1, 4'(b - 8'h37)};
      default:       return 5'd0;
    endcase
  endfunction

  function automatic logic [2:0] utf8_len(input logic [31:0] c);
    if (c <= ONE_BYTE_MAX)      return 3'd1;
    else if (c <= 32'h7FF)      return 3'd2;
    else if (c <= 32'hFFFF)     return 3'd3;
    else if (c <= 32'h1F_FFFF)  return 3'd4;
    else if (c <= 32'h3FF_FFFF) return 3'd5;
    else                        return 3'd6;
  endfunction

  function automatic logic [7:0] utf8_lead(input logic [2:0] n);
    case (n)
      3'd2:    return 8'hC0;
      3'd3:    return 8'hE0;
      3'd4:    return 8'hF0;
      3'd5:    return 8'hF8;
      3'd6:    return 8'hFC;
      default: return 8'h00;
    endcase
  endfunction

  // Decode state
  logic        at_start_q, at_start_d;
  phase_e      phase_q, phase_d;
  logic [3:0]  needed_q, needed_d;
  logic [3:0]  seen_q, seen_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  letter_q, letter_d;
  logic [7:0]  digits_q [8];
  logic        dig_we;

  // Result plan of the last input transfer
  logic [3:0]  rep_q, rep_d;
  tail_e       tail_q, tail_d;
  logic [7:0]  tail_byte_q, tail_byte_d;
  logic [2:0]  utf_n_q, utf_n_d;
  logic        bad_q, bad_d;
  logic        end_q, end_d;
  logic [3:0]  total_q, total_d;
  logic [3:0]  idx_q;

  // Output register
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        byte_valid_q, bad_escape_q, run_last_q, string_end_q;

  logic [4:0]  hx;
  logic [31:0] acc_new;
  logic [3:0]  seen_new;
  logic [3:0]  tail_cnt;

  assign hx       = hex_digit(in_byte_i);
  assign acc_new  = {acc_q[27:0], hx[3:0]};
  assign seen_new = seen_q + 4'd1;

  always_comb begin
    at_start_d  = at_start_q;
    phase_d     = phase_q;
    needed_d    = needed_q;
    seen_d      = seen_q;
    acc_d       = acc_q;
    letter_d    = letter_q;
    dig_we      = 1'b0;
    rep_d       = 4'd0;
    tail_d      = TAIL_NONE;
    tail_byte_d = in_byte_i;
    utf_n_d     = utf8_len(acc_new);
    bad_d       = 1'b0;
    end_d       = 1'b0;

    if (is_last_i) begin
      // closing quote: replay an open hex escape, else end marker
      if (!at_start_q && phase_q == PH_HEX) begin
        rep_d = seen_q + 4'd1;
        bad_d = 1'b1;
      end else begin
        tail_d = TAIL_MARK;
        bad_d  = !at_start_q && phase_q == PH_ESC;
      end
      end_d      = 1'b1;
      at_start_d = 1'b1;
      phase_d    = PH_TEXT;
      seen_d     = 4'd0;
      needed_d   = 4'd0;
    end else if (at_start_q) begin
      // opening quote: drop
      at_start_d = 1'b0;
      phase_d    = PH_TEXT;
      seen_d     = 4'd0;
      needed_d   = 4'd0;
    end else begin
      case (phase_q)
        PH_ESC: begin
          phase_d = PH_TEXT;
          tail_d  = TAIL_BYTE;
          case (in_byte_i)
            "a":     tail_byte_d = 8'h07;
            "b":     tail_byte_d = 8'h08;
            "t":     tail_byte_d = 8'h09;
            "n":     tail_byte_d = 8'h0A;
            "v":     tail_byte_d = 8'h0B;
            "f":     tail_byte_d = 8'h0C;
            "r":     tail_byte_d = 8'h0D;
            "e":     tail_byte_d = ESC_CODE;
            "x", "u", "U": begin
              tail_d   = TAIL_NONE;
              phase_d  = PH_HEX;
              needed_d = (in_byte_i == "x") ? 4'd2 : ((in_byte_i == "u") ? 4'd4 : 4'd8);
              seen_d   = 4'd0;
              acc_d    = 32'd0;
              letter_d = in_byte_i;
            end
            default: tail_byte_d = in_byte_i;
          endcase
        end
        PH_HEX: begin
          if (!hx[4]) begin
            // not a digit: replay, then treat the byte as plain text, or a backslash as a new escape
            rep_d  = seen_q + 4'd1;
            bad_d  = 1'b1;
            seen_d = 4'd0;
            if (in_byte_i == BACKSLASH) begin
              phase_d = PH_ESC;
            end else begin
              phase_d = PH_TEXT;
              tail_d  = TAIL_BYTE;
            end
          end else begin
            dig_we = 1'b1;
            seen_d = seen_new;
            acc_d  = acc_new;
            if (seen_new >= needed_q || seen_new[3]) begin
              phase_d = PH_TEXT;
              seen_d  = 4'd0;
              if (acc_new[31]) begin
                rep_d = seen_new + 4'd1;
                bad_d = 1'b1;
              end else begin
                tail_d = TAIL_UTF8;
              end
            end
          end
        end
        default: begin
          phase_d = PH_TEXT;
          if (in_byte_i == BACKSLASH) phase_d = PH_ESC;
          else                        tail_d  = TAIL_BYTE;
        end
      endcase
    end

    case (tail_d)
      TAIL_BYTE, TAIL_MARK: tail_cnt = 4'd1;
      TAIL_UTF8:            tail_cnt = {1'b0, utf_n_d};
      default:              tail_cnt = 4'd0;
    endcase
    total_d = rep_d + tail_cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      phase_q    <= PH_TEXT;
      needed_q   <= 4'd0;
      seen_q     <= 4'd0;
      rep_q      <= 4'd0;
      tail_q     <= TAIL_NONE;
      bad_q      <= 1'b0;
      end_q      <= 1'b0;
      total_q    <= 4'd0;
      idx_q      <= 4'd0;
    end else begin
      if (cmd_i.load) begin
        at_start_q <= at_start_d;
        phase_q    <= phase_d;
        needed_q   <= needed_d;
        seen_q     <= seen_d;
        rep_q      <= rep_d;
        tail_q     <= tail_d;
        bad_q      <= bad_d;
        end_q      <= end_d;
        total_q    <= total_d;
        idx_q      <= 4'd0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_q       <= acc_d;
      letter_q    <= letter_d;
      tail_byte_q <= tail_byte_d;
      utf_n_q     <= utf_n_d;
      if (dig_we) digits_q[seen_q[2:0]] <= in_byte_i;
    end
  end

  // Result selection at idx_q
  logic [3:0]  rel;
  logic [2:0]  tpos;
  logic [2:0]  kshift;
  logic [31:0] shifted;
  logic [7:0]  utf_byte;
  logic [2:0]  dig_rd_idx;
  logic [7:0]  res_byte;
  logic        res_valid;
  logic        is_final;

  assign rel        = idx_q - rep_q;
  assign tpos       = rel[2:0];
  assign kshift     = utf_n_q - 3'd1 - tpos;
  assign dig_rd_idx = 3'(idx_q - 4'd1);
  assign is_final   = (idx_q + 4'd1) == total_q;

  always_comb begin
    case (kshift)
      3'd1:    shifted = acc_q >> 6;
      3'd2:    shifted = acc_q >> 12;
      3'd3:    shifted = acc_q >> 18;
      3'd4:    shifted = acc_q >> 24;
      3'd5:    shifted = acc_q >> 30;
      default: shifted = acc_q;
    endcase
    if (tpos == 3'd0) utf_byte = utf8_lead(utf_n_q) | shifted[7:0];
    else              utf_byte = CONT_TAG | (shifted[7:0] & CONT_MASK);

    res_valid = 1'b1;
    if (idx_q < rep_q) begin
      res_byte = (idx_q == 4'd0) ? letter_q : digits_q[dig_rd_idx];
    end else begin
      case (tail_q)
        TAIL_UTF8: res_byte = utf_byte;
        TAIL_MARK: begin
          res_byte  = 8'h00;
          res_valid = 1'b0;
        end
        default:   res_byte = tail_byte_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      out_byte_q   <= res_byte;
      byte_valid_q <= res_valid;
      bad_escape_q <= bad_q && idx_q == 4'd0;
      run_last_q   <= is_final;
      string_end_q <= is_final && end_q;
    end
  end

  assign sts_o.has_more = idx_q != total_q;
  assign sts_o.is_final = is_final;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = byte_valid_q;
  assign bad_escape_o = bad_escape_q;
  assign run_last_o   = run_last_q;
  assign string_end_o = string_end_q;

  a_step_in_plan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> idx_q != total_q)
    else $error("result step beyond the planned count");

  a_load_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> idx_q == total_q)
    else $error("new input taken while results remain");

  a_final_marks_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step && is_final |=> out_valid_q && run_last_q)
    else $error("last planned result not flagged run_last");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && string_end_q |-> run_last_q)
    else $error("string_end without run_last");

endmodule

[design/seu_ctrl.sv]
// Escape decoder controller: takes one input transfer, then steps its results out.
module seu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  seu_pkg::seu_sts_t sts_i,
  output seu_pkg::seu_cmd_t cmd_o
);
  import seu_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;

  always_comb begin
    cmd_o.load = in_valid_i && ready_q;
    cmd_o.step = state_q == S_RUN && sts_i.has_more && sts_i.out_free;
    state_d    = state_q;
    case (state_q)
      S_IDLE:  if (cmd_o.load) state_d = S_RUN;
      S_RUN:   if (!sts_i.has_more || (cmd_o.step && sts_i.is_final)) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    ready_d = state_d == S_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

  assign in_ready_o = ready_q;

endmodule

[design/string_escape_to_utf8_unit.sv]
// Top level of the quoted-literal escape decoder with UTF-8 output.
//
//   channel | dir | payload                                              | transfer when
//   --------+-----+------------------------------------------------------+----------------
//   in_i    | in  | in_byte[7:0], is_last                                | valid & ready
//   out_o   | out | out_byte[7:0], byte_valid, bad_escape, run_last,     | valid & ready
//           |     | string_end                                           |
//
// Results: an input transfer is taken only while no planned results remain, and a replay can
// reach nine bytes; the result sequencer writes one byte a cycle into the single output
// register while that register is free.
// Reset: rst_ni is asynchronous, active low; ready in the first cycle after reset, no clearing.
// Stalls: while out_o.ready is low a result waits in the output register and the sequencer
// holds; a new input transfer is taken the cycle after the last result enters that register.
module string_escape_to_utf8_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  seu_in_if.sink    in_i,
  seu_out_if.source out_o
);
  import seu_pkg::*;

  seu_cmd_t cmd;
  seu_sts_t sts;

  // Sequence: accept one transfer, plan its results, step them out.
  seu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Decode state, escape digit store and output register.
  seu_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_byte_i    (in_i.in_byte),
    .is_last_i    (in_i.is_last),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_byte_o   (out_o.out_byte),
    .byte_valid_o (out_o.byte_valid),
    .bad_escape_o (out_o.bad_escape),
    .run_last_o   (out_o.run_last),
    .string_end_o (out_o.string_end)
  );

endmodule
